/* rtl/tws_pkg.sv */
// Shared types, codes and helpers for the three-wire serial master.
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

  localparam int unsigned TickW    = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ShiftW   = 16;
  localparam int unsigned BitIdxW  = 5;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [BitIdxW-1:0] TotalBits = BitIdxW'(16);
  localparam logic [BitIdxW-1:0] ReadBits  = BitIdxW'(8);
  localparam logic [ByteW-1:0]   ReadFlag  = ByteW'(8'h01);

  localparam logic [TickW-1:0] SetupTicksRst = TickW'(32);
  localparam logic [TickW-1:0] HalfTicksRst  = TickW'(8);

  // command codes
  localparam logic [CmdW-1:0] CMD_NONE  = 2'd0;
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd2;

  // register indexes (paddr word select)
  localparam logic REG_SETUP_TICKS = 1'b0;
  localparam logic REG_HALF_TICKS  = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_SETUP = 5'b00010,
    PH_HIGH  = 5'b00100,
    PH_LOW   = 5'b01000,
    PH_HOLD  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0] setup_ticks;
    logic [TickW-1:0] half_ticks;
  } cfg_t;

  typedef struct packed {
    logic             chip_enable;
    logic             serial_clock;
    logic             io_out;
    logic             io_drive;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] read_data;
  } pins_t;

  // remaining-tick count for a stretch; zero acts as one
  function automatic logic [TickW-1:0] load_count(input logic [TickW-1:0] ticks);
    logic [TickW-1:0] res;
    res = (ticks == '0) ? '0 : ticks - TickW'(1);
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/tws_engine.sv */
// Transfer sequencer: state registers and next-state/pin logic for one tick.
`timescale 1ns / 1ps
`default_nettype none

module tws_engine (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire tws_pkg::cfg_t             cfg,
  input  wire logic [tws_pkg::CmdW-1:0]  command,
  input  wire logic [tws_pkg::ByteW-1:0] address,
  input  wire logic [tws_pkg::ByteW-1:0] write_data,
  input  wire logic                      io_in,
  output tws_pkg::pins_t                 pins_next
);
  import tws_pkg::*;

  phase_t              phase, phase_next;
  logic [BitIdxW-1:0]  bit_index, bit_index_next;
  logic [ShiftW-1:0]   out_shift, out_shift_next;
  logic [ByteW-1:0]    in_shift, in_shift_next;
  logic [TickW-1:0]    tick_count, tick_count_next;
  logic                is_read, is_read_next;
  logic                done;
  logic                sampling;
  logic                in_frame;

  // read bits are sampled on the way into the clock-high stretch
  assign sampling = is_read && (bit_index >= ReadBits);

  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    out_shift_next  = out_shift;
    in_shift_next   = in_shift;
    tick_count_next = tick_count;
    is_read_next    = is_read;
    done            = 1'b0;

    case (phase)
      PH_SETUP: begin
        if (tick_count == '0) begin
          if (sampling) in_shift_next = {io_in, in_shift[ByteW-1:1]};
          phase_next      = PH_HIGH;
          tick_count_next = load_count(cfg.half_ticks);
        end else begin
          tick_count_next = tick_count - TickW'(1);
        end
      end
      PH_HIGH: begin
        if (tick_count == '0) begin
          out_shift_next  = out_shift >> 1;
          bit_index_next  = bit_index + BitIdxW'(1);
          phase_next      = PH_LOW;
          tick_count_next = load_count(cfg.half_ticks);
        end else begin
          tick_count_next = tick_count - TickW'(1);
        end
      end
      PH_LOW: begin
        if (tick_count == '0) begin
          if (bit_index >= TotalBits) begin
            phase_next      = PH_HOLD;
            tick_count_next = load_count(cfg.setup_ticks);
          end else begin
            if (sampling) in_shift_next = {io_in, in_shift[ByteW-1:1]};
            phase_next      = PH_HIGH;
            tick_count_next = load_count(cfg.half_ticks);
          end
        end else begin
          tick_count_next = tick_count - TickW'(1);
        end
      end
      PH_HOLD: begin
        if (tick_count == '0) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end else begin
          tick_count_next = tick_count - TickW'(1);
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (command inside {CMD_WRITE, CMD_READ}) begin
          is_read_next    = (command == CMD_READ);
          out_shift_next  = (command == CMD_READ)
                          ? {{(ShiftW-ByteW){1'b0}}, address | ReadFlag}
                          : {write_data, address};
          bit_index_next  = '0;
          phase_next      = PH_SETUP;
          tick_count_next = load_count(cfg.setup_ticks);
        end
      end
    endcase
  end

  // pin levels follow the updated state
  assign in_frame = (phase_next == PH_SETUP) || (phase_next == PH_HIGH)
                 || (phase_next == PH_LOW);

  always_comb begin
    pins_next.chip_enable  = in_frame;
    pins_next.serial_clock = (phase_next == PH_HIGH);
    if (((phase_next == PH_HIGH) || (phase_next == PH_LOW)) && is_read_next
        && (bit_index_next >= ReadBits)) begin
      pins_next.io_drive = 1'b0;
      pins_next.io_out   = 1'b0;
    end else begin
      pins_next.io_drive = 1'b1;
      pins_next.io_out   = in_frame & out_shift_next[0];
    end
    pins_next.busy      = (phase_next != PH_IDLE);
    pins_next.done      = done;
    pins_next.read_data = (done && is_read_next) ? in_shift_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= '0;
      out_shift  <= '0;
      in_shift   <= '0;
      tick_count <= '0;
      is_read    <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      out_shift  <= out_shift_next;
      in_shift   <= in_shift_next;
      tick_count <= tick_count_next;
      is_read    <= is_read_next;
    end
  end

  // at most sixteen bits, bit zero at the start of setup, all bits before hold
  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= TotalBits)
    else $error("bit index past end of frame");
  a_idle_starts_setup: assert property (@(posedge clk) disable iff (rst)
    advance && (phase == PH_IDLE) && (phase_next != PH_IDLE) |=>
      (phase == PH_SETUP) && (bit_index == '0))
    else $error("transfer did not start in setup");
  a_hold_after_frame: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HOLD) |-> (bit_index == TotalBits))
    else $error("hold entered before all bits clocked");

endmodule

`default_nettype wire

/* rtl/three_wire_serial_master_core.sv */
// Top level of the three-wire serial master: handshake, result register, APB registers.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  in       | in_valid / in_ready        | command, address, write_data, io_in
//  out      | out_valid / out_ready      | chip_enable, serial_clock, io_out,
//           |                            | io_drive, busy_res, done_res, read_data
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Each item is one pin tick: the sequencer state and the pin levels for that
// tick are updated at the accepting edge and the result sits in the output
// register from the next cycle on.
// in_ready is high whenever the output register is empty or being taken,
// so one item per cycle is sustained while out_ready stays high.
// A stall on the output side freezes the sequencer; pin timing is counted in
// accepted items, not in clock cycles.
// Reset puts the sequencer in idle and loads the tick registers with 32 and 8.

module three_wire_serial_master_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input items
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tws_pkg::CmdW-1:0]     command,
  input  wire logic [tws_pkg::ByteW-1:0]    address,
  input  wire logic [tws_pkg::ByteW-1:0]    write_data,
  input  wire logic                         io_in,
  // result items
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              chip_enable,
  output logic                              serial_clock,
  output logic                              io_out,
  output logic                              io_drive,
  output logic                              busy_res,
  output logic                              done_res,
  output logic [tws_pkg::ByteW-1:0]         read_data,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tws_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [tws_pkg::ApbDataW-1:0] pwdata,
  output logic [tws_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready
);
  import tws_pkg::*;

  cfg_t  cfg;
  pins_t pins_next;
  pins_t pins;
  logic  in_take;
  logic  cfg_write;
  logic  reg_sel;

  // ---- configuration registers -------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_ticks <= SetupTicksRst;
      cfg.half_ticks  <= HalfTicksRst;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_SETUP_TICKS: cfg.setup_ticks <= pwdata[TickW-1:0];
        REG_HALF_TICKS:  cfg.half_ticks  <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SETUP_TICKS: prdata = {{(ApbDataW-TickW){1'b0}}, cfg.setup_ticks};
      REG_HALF_TICKS:  prdata = {{(ApbDataW-TickW){1'b0}}, cfg.half_ticks};
      default:         prdata = '0;
    endcase
  end

  // ---- item handshake ------------------------------------------------------
  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  tws_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .advance    (in_take),
    .cfg        (cfg),
    .command    (command),
    .address    (address),
    .write_data (write_data),
    .io_in      (io_in),
    .pins_next  (pins_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) pins <= pins_next;
  end

  assign chip_enable  = pins.chip_enable;
  assign serial_clock = pins.serial_clock;
  assign io_out       = pins.io_out;
  assign io_drive     = pins.io_drive;
  assign busy_res     = pins.busy;
  assign done_res     = pins.done;
  assign read_data    = pins.read_data;

  // ---- checks --------------------------------------------------------------
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !chip_enable)
    else $error("done flagged while still busy");
  a_clock_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && serial_clock |-> chip_enable && busy_res)
    else $error("serial clock outside chip enable");
  a_released_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !io_drive |-> !io_out && chip_enable)
    else $error("released data pin outside a read frame");
  a_read_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != '0) |-> done_res)
    else $error("read data shown without done");

endmodule

`default_nettype wire

/* verif/tws_pin_checker.sv */
// Pin-level predictor and result comparison for the three-wire serial master.
`timescale 1ns / 1ps

module tws_pin_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [tws_pkg::CmdW-1:0]     command,
  input  logic [tws_pkg::ByteW-1:0]    address,
  input  logic [tws_pkg::ByteW-1:0]    write_data,
  input  logic                         io_in,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         chip_enable,
  input  logic                         serial_clock,
  input  logic                         io_out,
  input  logic                         io_drive,
  input  logic                         busy_res,
  input  logic                         done_res,
  input  logic [tws_pkg::ByteW-1:0]    read_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [tws_pkg::ApbAddrW-1:0] paddr,
  input  logic [tws_pkg::ApbDataW-1:0] pwdata,
  output int                           fail_cnt,
  output int                           pending
);
  import tws_pkg::*;

  // predicted sequencer state
  phase_t             seq_ph;
  logic [BitIdxW-1:0] bit_no;
  logic [ShiftW-1:0]  tx_sr;
  logic [ByteW-1:0]   rx_sr;
  logic [TickW-1:0]   ticks_left;
  logic               rd_xfer;
  logic [TickW-1:0]   setup_cfg;
  logic [TickW-1:0]   half_cfg;

  pins_t pins_due[$];

  // remaining ticks after the first one of a stretch; zero acts as one
  function automatic logic [TickW-1:0] stretch(input logic [TickW-1:0] r);
    return (r == '0) ? '0 : r - 1'b1;
  endfunction

  // clock rise; read bits are sampled just before it
  function automatic void clock_rise(input logic pin);
    if (rd_xfer && bit_no >= ReadBits)
      rx_sr = {pin, rx_sr[ByteW-1:1]};
    seq_ph = PH_HIGH;
    ticks_left = stretch(half_cfg);
  endfunction

  function automatic pins_t next_pins(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] adr,
                                      input logic [ByteW-1:0] wd, input logic pin);
    pins_t p;
    logic  fin;
    logic  active;
    fin = 1'b0;
    case (seq_ph)
      PH_SETUP: begin
        if (ticks_left == '0) clock_rise(pin);
        else ticks_left = ticks_left - 1'b1;
      end
      PH_HIGH: begin
        if (ticks_left == '0) begin
          tx_sr = tx_sr >> 1;
          bit_no = bit_no + 1'b1;
          seq_ph = PH_LOW;
          ticks_left = stretch(half_cfg);
        end else begin
          ticks_left = ticks_left - 1'b1;
        end
      end
      PH_LOW: begin
        if (ticks_left != '0) begin
          ticks_left = ticks_left - 1'b1;
        end else if (bit_no >= TotalBits) begin
          seq_ph = PH_HOLD;
          ticks_left = stretch(setup_cfg);
        end else begin
          clock_rise(pin);
        end
      end
      PH_HOLD: begin
        if (ticks_left == '0) begin
          seq_ph = PH_IDLE;
          fin = 1'b1;
        end else begin
          ticks_left = ticks_left - 1'b1;
        end
      end
      default: begin
        seq_ph = PH_IDLE;
        if (cmd == CMD_WRITE || cmd == CMD_READ) begin
          rd_xfer = (cmd == CMD_READ);
          tx_sr = rd_xfer ? ShiftW'(adr | ReadFlag) : {wd, adr};
          bit_no = '0;
          seq_ph = PH_SETUP;
          ticks_left = stretch(setup_cfg);
        end
      end
    endcase
    active = (seq_ph == PH_SETUP) || (seq_ph == PH_HIGH) || (seq_ph == PH_LOW);
    p.chip_enable = active;
    p.serial_clock = (seq_ph == PH_HIGH);
    if ((seq_ph == PH_HIGH || seq_ph == PH_LOW) && rd_xfer && bit_no >= ReadBits) begin
      p.io_drive = 1'b0;
      p.io_out = 1'b0;
    end else begin
      p.io_drive = 1'b1;
      p.io_out = active & tx_sr[0];
    end
    p.busy = (seq_ph != PH_IDLE);
    p.done = fin;
    p.read_data = (fin && rd_xfer) ? rx_sr : '0;
    return p;
  endfunction

  function automatic void check_field(input string name, input logic [ByteW-1:0] exp_v,
                                      input logic [ByteW-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_cnt++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin : watch
    pins_t exp_p;
    if (rst) begin
      seq_ph = PH_IDLE;
      bit_no = '0;
      tx_sr = '0;
      rx_sr = '0;
      ticks_left = '0;
      rd_xfer = 1'b0;
      setup_cfg = SetupTicksRst;
      half_cfg = HalfTicksRst;
      pins_due.delete();
      fail_cnt = 0;
    end else begin
      // results leave before the item of this edge is predicted
      if (out_valid && out_ready) begin
        if (pins_due.size() == 0) begin
          fail_cnt++;
          $display("%0t: result expected none actual busy=%0b done=%0b", $time,
                   busy_res, done_res);
        end else begin
          exp_p = pins_due.pop_front();
          check_field("chip_enable", exp_p.chip_enable, chip_enable);
          check_field("serial_clock", exp_p.serial_clock, serial_clock);
          check_field("io_out", exp_p.io_out, io_out);
          check_field("io_drive", exp_p.io_drive, io_drive);
          check_field("busy_res", exp_p.busy, busy_res);
          check_field("done_res", exp_p.done, done_res);
          check_field("read_data", exp_p.read_data, read_data);
        end
      end
      if (in_valid && in_ready)
        pins_due.push_back(next_pins(command, address, write_data, io_in));
      // a register written at this edge counts from the next item on
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HALF_TICKS) half_cfg = pwdata[TickW-1:0];
        else setup_cfg = pwdata[TickW-1:0];
      end
    end
    pending = pins_due.size();
  end

endmodule

/* verif/tb_top.sv */
// Top of the three-wire serial master testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tws_pkg::*;

  // command code with no meaning; the block must treat it as none
  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [CmdW-1:0]     command;
  logic [ByteW-1:0]    address;
  logic [ByteW-1:0]    write_data;
  logic                io_in;
  logic                out_valid;
  logic                out_ready;
  logic                chip_enable;
  logic                serial_clock;
  logic                io_out;
  logic                io_drive;
  logic                busy_res;
  logic                done_res;
  logic [ByteW-1:0]    read_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int fail_cnt;
  int pending;

  // calm: no idling on either side (end of run)
  // hold_req: one-shot request for a long receiver hold-off
  bit calm;
  bit hold_req;

  // tick settings currently programmed, used to size the long transfers
  logic [TickW-1:0] setup_now;
  logic [TickW-1:0] half_now;

  // random phases: tick settings and item count of each
  int unsigned phase_setup [9] = '{1, 2, 0, 3, 255, 1, 2, 5, 1};
  int unsigned phase_half  [9] = '{1, 0, 2, 3, 1, 2, 1, 1, 1};
  int unsigned phase_items [9] = '{60, 60, 60, 60, 120, 60, 60, 60, 60};

  three_wire_serial_master_core i_dut (.*);

  tws_pin_checker i_pin_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stall bursts, plus the one long hold-off on request.
  // The hold-off counts cycles, not results, so the single output register
  // fills and in_ready drops while the sender keeps offering.
  initial begin : rx_side
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (64) @(negedge clk);
        hold_req = 1'b0;
        out_ready = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // One tick item. Called at a falling edge, returns at the falling edge
  // after acceptance with valid still high, so back-to-back items keep
  // valid up; a random gap lowers it first.
  task automatic drive_tick(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] adr,
                            input logic [ByteW-1:0] wd, input logic pin);
    int gap;
    if (!calm && !hold_req && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    address = adr;
    write_data = wd;
    io_in = pin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // ticks with no command; data pin all ones or random
  task automatic quiet_ticks(input int n, input bit ones);
    repeat (n) drive_tick(CMD_NONE, 8'($urandom), 8'($urandom), ones ? 1'b1 : 1'($urandom));
  endtask

  // mostly no command, so transfers run to completion between the commands
  // that start them; commands landing mid-transfer must be ignored
  task automatic random_tick();
    int pick;
    logic [CmdW-1:0] cmd;
    pick = $urandom_range(0, 19);
    if (pick < 12) cmd = CMD_NONE;
    else if (pick < 15) cmd = CMD_WRITE;
    else if (pick < 18) cmd = CMD_READ;
    else cmd = CMD_SPARE;
    drive_tick(cmd, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // sender pauses until every predicted result has been taken
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  // Upper data bits are junk; only the low byte holds the tick count.
  task automatic write_reg(input logic sel, input logic [TickW-1:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {sel, 2'b00};
    pwdata = {24'($urandom), val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (sel == REG_HALF_TICKS) half_now = val;
    else setup_now = val;
  endtask

  // one full transfer at the current settings, padded past its done tick
  task automatic whole_transfer(input logic [CmdW-1:0] cmd);
    int s;
    int h;
    s = (setup_now == '0) ? 1 : int'(setup_now);
    h = (half_now == '0) ? 1 : int'(half_now);
    drive_tick(cmd, 8'($urandom), 8'($urandom), 1'($urandom));
    quiet_ticks(2 * s + 32 * h + 1, 1'b0);
  endtask

  initial begin : stim
    int ph;
    int k;
    rst = 1'b1;
    calm = 1'b0;
    hold_req = 1'b0;
    in_valid = 1'b0;
    command = CMD_NONE;
    address = '0;
    write_data = '0;
    io_in = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    setup_now = SetupTicksRst;
    half_now = HalfTicksRst;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset tick settings, before any register write
    whole_transfer(CMD_WRITE);
    drain();

    // directed: both registers zero, which must act as one tick each
    write_reg(REG_SETUP_TICKS, 8'd0);
    write_reg(REG_HALF_TICKS, 8'd0);
    drive_tick(CMD_WRITE, 8'hFF, 8'h00, 1'b0);
    // a read command in the middle of the write is ignored
    for (k = 1; k <= 33; k++)
      drive_tick((k == 10) ? CMD_READ : CMD_NONE, 8'h5A, 8'hC3, 1'($urandom));
    // first one lands on the done tick and is ignored; second starts a read
    // of address zero, which goes out with the read flag set
    drive_tick(CMD_READ, 8'h00, 8'hFF, 1'b1);
    drive_tick(CMD_READ, 8'h00, 8'hFF, 1'b1);
    quiet_ticks(34, 1'b1);
    // spare command code while idle
    drive_tick(CMD_SPARE, 8'hFF, 8'hFF, 1'b0);
    drive_tick(CMD_SPARE, 8'hFF, 8'hFF, 1'b1);
    drive_tick(CMD_WRITE, 8'h00, 8'hFF, 1'b0);
    quiet_ticks(34, 1'b0);
    drive_tick(CMD_READ, 8'hFE, 8'h00, 1'b0);
    quiet_ticks(34, 1'b0);
    drain();

    // longest setup and hold, one full read
    write_reg(REG_SETUP_TICKS, 8'd255);
    write_reg(REG_HALF_TICKS, 8'd1);
    whole_transfer(CMD_READ);
    drain();

    // random phases; a phase often ends mid-transfer, so the next register
    // write lands while the sequencer is still busy
    for (ph = 0; ph < 9; ph++) begin
      drain();
      calm = (ph == 8);
      write_reg(REG_SETUP_TICKS, TickW'(phase_setup[ph]));
      write_reg(REG_HALF_TICKS, TickW'(phase_half[ph]));
      for (k = 0; k < int'(phase_items[ph]); k++) begin
        if (ph == 3 && k == 30) hold_req = 1'b1;
        random_tick();
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
